### sv/cnv_pkg.sv
// Shared types, codes and constants for the chiptune note voice.
// No dependencies; used by cnv_ctrl, cnv_datapath and chiptune_note_voice_unit.
`default_nettype none

package cnv_pkg;

	// Default widths, handed down as module parameters
	localparam int PHASE_BITS_DEF = 24;
	localparam int COUNT_BITS_DEF = 16;

	// Configuration port
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 2;
	localparam logic [CFG_IDX_W-1:0] REG_NOTE_LENGTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MELODY_GAIN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BASS_GAIN   = 2'd2;

	// Register reset values
	localparam logic [15:0] NOTE_LENGTH_RST = 16'd8820;
	localparam logic [15:0] MELODY_GAIN_RST = 16'd9830;
	localparam logic [15:0] BASS_GAIN_RST   = 16'd6554;

	// Envelope: decay over last 3528 samples (8 * 441), attack over 220.5 samples
	localparam logic [15:0] DECAY_LEN    = 16'd3528;
	localparam logic [15:0] ATTACK_LIMIT = 16'd221;
	localparam logic [15:0] Q15_ONE      = 16'd32768;

	// floor(x / 441) = (x * RECIP_M) >> RECIP_SHIFT, exact for x below 2^26
	localparam logic [24:0] RECIP_M     = 25'd19478310;
	localparam int          RECIP_SHIFT = 33;

	// Output scaling, clip at +-2^45 in the Q.45 product
	localparam logic [13:0] OUT_SCALE  = 14'd9000;
	localparam logic [45:0] CLIP_LIMIT = 46'h2000_0000_0000;

	// Channel payloads
	typedef struct packed {
		logic        note_start;
		logic [23:0] melody_step;
		logic [23:0] bass_step;
	} cnv_in_t;

	typedef struct packed {
		logic signed [14:0] sample;
		logic               note_last;
	} cnv_out_t;

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ENV,
		ST_MIX,
		ST_SCALE
	} cnv_state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic load_a;
		logic load_env;
		logic load_v;
		logic load_out;
	} cnv_cmd_t;

endpackage

`default_nettype wire

### sv/chiptune_note_voice_unit.sv
// An input transfer loads stage 1; the envelope, mix and scale steps follow and load
// the output register. No new input is taken until the controller is back in idle;
// each of the envelope, mix and scale multipliers runs in one step of the controller sequence.
// A held result does not block the next input; the sequence waits only at the
// final step while the output register is still full.
// Reset (arst_n low, asynchronous): registers to defaults, phases, count and steps to zero.
`default_nettype none

module chiptune_note_voice_unit #(
	parameter int PHASE_BITS = cnv_pkg::PHASE_BITS_DEF,
	parameter int COUNT_BITS = cnv_pkg::COUNT_BITS_DEF
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            cfg_we,
	input  wire  [cnv_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire  [cnv_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire                            in_valid,
	output logic                           in_stall,
	input  wire  cnv_pkg::cnv_in_t         in_data,
	output logic                           out_valid,
	input  wire                            out_stall,
	output cnv_pkg::cnv_out_t              out_data
);

	cnv_pkg::cnv_cmd_t cmd;

	// sequencing
	cnv_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	// arithmetic and state
	cnv_datapath #(
		.PHASE_BITS (PHASE_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

### sv/cnv_ctrl.sv
// Sequencing controller for the note voice: state machine and output valid flag.
// Depends on cnv_pkg for the state enum and command struct.
`default_nettype none

module cnv_ctrl (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              in_valid,
	output logic             in_stall,
	output logic             out_valid,
	input  wire              out_stall,
	output cnv_pkg::cnv_cmd_t cmd
);

	cnv_pkg::cnv_state_t state_q;
	cnv_pkg::cnv_state_t state_nxt;
	logic                out_valid_q;

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			cnv_pkg::ST_IDLE: begin
				if (in_valid) state_nxt = cnv_pkg::ST_ENV;
			end
			cnv_pkg::ST_ENV:   state_nxt = cnv_pkg::ST_MIX;
			cnv_pkg::ST_MIX:   state_nxt = cnv_pkg::ST_SCALE;
			cnv_pkg::ST_SCALE: begin
				// wait here until the output register is free
				if (!out_valid_q || !out_stall) state_nxt = cnv_pkg::ST_IDLE;
			end
			default: state_nxt = cnv_pkg::ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		in_stall     = (state_q != cnv_pkg::ST_IDLE);
		cmd.load_a   = in_valid && (state_q == cnv_pkg::ST_IDLE);
		cmd.load_env = (state_q == cnv_pkg::ST_ENV);
		cmd.load_v   = (state_q == cnv_pkg::ST_MIX);
		cmd.load_out = (state_q == cnv_pkg::ST_SCALE) && (!out_valid_q || !out_stall);
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cnv_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Output valid: set on load, cleared on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	// an accepted item always starts the envelope step next
	a_accept_to_env: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == cnv_pkg::ST_ENV))
		else $error("accepted item did not enter envelope step");

	// at most one datapath load per cycle
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load_a, cmd.load_env, cmd.load_v, cmd.load_out}))
		else $error("more than one datapath command");

	// an output load always shows as a valid result
	a_load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> (out_valid_q && state_q == cnv_pkg::ST_IDLE))
		else $error("output load did not raise valid");

	// a pending result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |-> !cmd.load_out)
		else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire

### sv/cnv_datapath.sv
// Datapath of the note voice: config registers, phase and count state,
// envelope, mix, clip and output scaling. Depends on cnv_pkg.
`default_nettype none

module cnv_datapath #(
	parameter int PHASE_BITS = cnv_pkg::PHASE_BITS_DEF,
	parameter int COUNT_BITS = cnv_pkg::COUNT_BITS_DEF
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 cfg_we,
	input  wire  [cnv_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire  [cnv_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  wire  cnv_pkg::cnv_in_t              in_data,
	input  wire  cnv_pkg::cnv_cmd_t             cmd,
	output cnv_pkg::cnv_out_t                   out_data
);

	// compare width covering both the count and the 16-bit note length
	localparam int CW = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 1;

	// configuration registers
	logic [15:0] note_length_q;
	logic [15:0] melody_gain_q;
	logic [15:0] bass_gain_q;

	// voice state
	logic [COUNT_BITS-1:0] idx_q;
	logic [PHASE_BITS-1:0] mph_q;
	logic [PHASE_BITS-1:0] bph_q;
	logic [PHASE_BITS-1:0] msh_q;
	logic [PHASE_BITS-1:0] bsh_q;

	// stage registers
	logic [15:0]        decay_s1;
	logic [15:0]        attack_s1;
	logic signed [33:0] mix_s1;
	logic               last_s1;
	logic [15:0]        env_s2;
	logic [45:0]        absv_s3;
	logic               neg_s3;
	cnv_pkg::cnv_out_t  out_q;

	// current-sample operands
	logic [COUNT_BITS-1:0] cur_i;
	logic [PHASE_BITS-1:0] cur_mph;
	logic [PHASE_BITS-1:0] cur_bph;
	logic [PHASE_BITS-1:0] cur_msh;
	logic [PHASE_BITS-1:0] cur_bsh;
	logic [CW-1:0]         i_ext;
	logic [CW-1:0]         n_ext;
	logic [CW-1:0]         dn;
	logic                  in_note;
	logic [23:0]           x_d;
	logic [23:0]           x_a;
	logic [48:0]           q_d;
	logic [48:0]           q_a;
	logic [15:0]           decay_c;
	logic [15:0]           attack_c;
	logic [PHASE_BITS-1:0] half;
	logic [PHASE_BITS-1:0] tri_d;
	logic [PHASE_BITS+16:0] tri_sh;
	logic signed [17:0]    tri_q;
	logic signed [34:0]    bass_prod;
	logic signed [33:0]    mel_term;
	logic signed [33:0]    bass_term;
	logic [31:0]           env_prod;
	logic signed [50:0]    v_full;
	logic [50:0]           v_abs;
	logic [59:0]           scaled;
	logic [14:0]           mag;

	// config writes; other indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			note_length_q <= cnv_pkg::NOTE_LENGTH_RST;
			melody_gain_q <= cnv_pkg::MELODY_GAIN_RST;
			bass_gain_q   <= cnv_pkg::BASS_GAIN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				cnv_pkg::REG_NOTE_LENGTH: note_length_q <= cfg_data;
				cnv_pkg::REG_MELODY_GAIN: melody_gain_q <= cfg_data;
				cnv_pkg::REG_BASS_GAIN:   bass_gain_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// note start restarts phases and count and latches new steps
	always_comb begin
		cur_i   = in_data.note_start ? '0 : idx_q;
		cur_mph = in_data.note_start ? '0 : mph_q;
		cur_bph = in_data.note_start ? '0 : bph_q;
		cur_msh = in_data.note_start ? PHASE_BITS'(in_data.melody_step) : msh_q;
		cur_bsh = in_data.note_start ? PHASE_BITS'(in_data.bass_step) : bsh_q;
	end

	// envelope operands: samples left and sample index, divided by 441
	always_comb begin
		i_ext   = CW'(cur_i);
		n_ext   = CW'(note_length_q);
		in_note = (i_ext < n_ext);
		dn      = n_ext - i_ext;
		x_d     = {dn[11:0], 12'd0};
		x_a     = {cur_i[7:0], 16'd0};
		q_d     = 49'(x_d) * 49'(cnv_pkg::RECIP_M);
		q_a     = 49'(x_a) * 49'(cnv_pkg::RECIP_M);
		decay_c  = (dn >= CW'(cnv_pkg::DECAY_LEN)) ? cnv_pkg::Q15_ONE
			: q_d[cnv_pkg::RECIP_SHIFT +: 16];
		attack_c = (cur_i >= COUNT_BITS'(cnv_pkg::ATTACK_LIMIT)) ? cnv_pkg::Q15_ONE
			: q_a[cnv_pkg::RECIP_SHIFT +: 16];
	end

	// square melody and triangle bass mix, Q4.30
	always_comb begin
		half      = {1'b1, {(PHASE_BITS-1){1'b0}}};
		tri_d     = cur_bph[PHASE_BITS-1] ? (cur_bph - half) : (half - cur_bph);
		tri_sh    = {tri_d, 17'd0} >> PHASE_BITS;
		tri_q     = $signed({1'b0, tri_sh[16:0]}) - 18'sd32768;
		bass_prod = tri_q * $signed({1'b0, bass_gain_q});
		if (cur_msh == '0) begin
			mel_term = '0;
		end else if (!cur_mph[PHASE_BITS-1]) begin
			mel_term = $signed({3'b000, melody_gain_q, 15'd0});
		end else begin
			mel_term = -$signed({3'b000, melody_gain_q, 15'd0});
		end
		bass_term = (cur_bsh == '0) ? '0 : 34'(bass_prod);
	end

	// voice state update on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			mph_q <= '0;
			bph_q <= '0;
			msh_q <= '0;
			bsh_q <= '0;
		end else if (cmd.load_a) begin
			idx_q <= (cur_i == '1) ? cur_i : cur_i + 1'b1;
			mph_q <= cur_mph + cur_msh;
			bph_q <= cur_bph + cur_bsh;
			msh_q <= cur_msh;
			bsh_q <= cur_bsh;
		end
	end

	// stage 1: envelope terms and mix; past the note's end the mix is zero
	always_ff @(posedge clk) begin
		if (cmd.load_a) begin
			decay_s1  <= decay_c;
			attack_s1 <= attack_c;
			mix_s1    <= in_note ? (mel_term + bass_term) : '0;
			last_s1   <= in_note && (dn == CW'(1));
		end
	end

	// stage 2: envelope product
	assign env_prod = decay_s1 * attack_s1;

	always_ff @(posedge clk) begin
		if (cmd.load_env) env_s2 <= env_prod[30:15];
	end

	// stage 3: apply envelope, clip magnitude to 2^45
	always_comb begin
		v_full = mix_s1 * $signed({1'b0, env_s2});
		v_abs  = v_full[50] ? 51'(-v_full) : 51'(v_full);
	end

	always_ff @(posedge clk) begin
		if (cmd.load_v) begin
			neg_s3  <= v_full[50];
			absv_s3 <= (v_abs > 51'(cnv_pkg::CLIP_LIMIT)) ? cnv_pkg::CLIP_LIMIT
				: v_abs[45:0];
		end
	end

	// stage 4: scale by 9000, truncate toward zero
	always_comb begin
		scaled = 60'(absv_s3) * 60'(cnv_pkg::OUT_SCALE);
		mag    = {1'b0, scaled[58:45]};
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q.sample    <= neg_s3 ? $signed(-mag) : $signed(mag);
			out_q.note_last <= last_s1;
		end
	end

	assign out_data = out_q;

endmodule

`default_nettype wire
